@@ rtl/core/nra_pkg.sv @@
package nra_pkg;

  localparam int unsigned CfgW = 32;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [1:0] {
    CFG_PRUNE_INTERVAL  = 2'd0,
    CFG_ADVERT_PERIOD   = 2'd1,
    CFG_REGISTER_VECTOR = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_MESSAGE = 2'd0,
    OP_TICK    = 2'd1,
    OP_DUMP    = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    KIND_ACK    = 3'd0,
    KIND_JOIN   = 3'd1,
    KIND_PART   = 3'd2,
    KIND_ACTIVE = 3'd3,
    KIND_ADVERT = 3'd4,
    KIND_FULL   = 3'd5
  } kind_e;

  // Classified command handed from the front to the back.
  typedef enum logic [1:0] {
    CMD_REG  = 2'd0,
    CMD_TICK = 2'd1,
    CMD_DUMP = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] ip;
    logic [47:0] uid;
    logic [15:0] life;
  } cmd_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] ip;
    logic [47:0] uid;
    logic        last;
  } res_t;

endpackage

@@ rtl/core/node_registry_with_aging.sv @@
// Node registry with aging. Items enter through a small command queue and a
// sequencer works on one at a time against an entry memory with one write
// and one registered read port. A registration searches the stored entries
// one by one before its results; a tick scans them for pruning only when the
// prune interval is reached; a dump reads out every entry. Each item also
// waits while the result side stalls.
module node_registry_with_aging #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op_i,
  input  logic [31:0] src_ip_i,
  input  logic [31:0] msg_vector_i,
  input  logic [15:0] msg_length_i,
  input  logic [63:0] payload_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind_o,
  output logic [31:0] node_ip_o,
  output logic [47:0] node_uid_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  logic [15:0] prune_q, adv_q;
  logic [31:0] vec_q;
  logic        cv, cr, rv;
  nra_pkg::cmd_t cmd;
  nra_pkg::res_t res;

  // Write configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prune_q <= 16'd10;
      adv_q <= 16'd30;
      vec_q <= 32'd42;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nra_pkg::CFG_PRUNE_INTERVAL: prune_q <= cfg_data_i[15:0];
        nra_pkg::CFG_ADVERT_PERIOD: adv_q <= cfg_data_i[15:0];
        nra_pkg::CFG_REGISTER_VECTOR: vec_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  nra_front u_front (
    .clk_i, .rst_ni, .push, .full, .op_i, .src_ip_i, .msg_vector_i,
    .msg_length_i, .payload_i, .register_vector_i(vec_q),
    .cmd_valid_o(cv), .cmd_o(cmd), .cmd_ready_i(cr)
  );

  nra_back #(.TableDepth(TABLE_DEPTH)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cv), .cmd_i(cmd), .cmd_ready_o(cr),
    .prune_interval_i(prune_q), .advert_period_i(adv_q),
    .res_valid_o(rv), .res_o(res), .res_ready_i(pop)
  );

  assign empty = !rv;
  assign kind_o = res.kind;
  assign node_ip_o = res.ip;
  assign node_uid_o = res.uid;
  assign last_o = res.last;

endmodule

@@ rtl/core/nra_front.sv @@
module nra_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          op_i,
  input  logic [31:0]         src_ip_i,
  input  logic [31:0]         msg_vector_i,
  input  logic [15:0]         msg_length_i,
  input  logic [63:0]         payload_i,
  input  logic [31:0]         register_vector_i,
  output logic                cmd_valid_o,
  output nra_pkg::cmd_t       cmd_o,
  input  logic                cmd_ready_i
);

  // Two-entry command queue.
  nra_pkg::cmd_t q_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, rd_d;
  logic       keep;
  logic       wr, rd;
  nra_pkg::cmd_t c;

  assign full = (cnt_q == 2'd2);

  // Classify the item; drop messages that are not registrations.
  always_comb begin
    c.ip  = src_ip_i;
    c.uid = payload_i[63:16];
    c.life = payload_i[15:0];
    c.cmd = nra_pkg::CMD_REG;
    keep = 1'b0;
    case (op_i)
      nra_pkg::OP_MESSAGE: begin
        keep = (msg_vector_i == register_vector_i) && (msg_length_i == 16'd8);
      end
      nra_pkg::OP_TICK: begin
        c.cmd = nra_pkg::CMD_TICK;
        keep = 1'b1;
      end
      nra_pkg::OP_DUMP: begin
        c.cmd = nra_pkg::CMD_DUMP;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign wr = push && !full && keep;
  assign rd = cmd_valid_o && cmd_ready_i;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = q_q[rd_q];

  always_comb begin
    cnt_d = cnt_q + {1'b0, wr} - {1'b0, rd};
    rd_d = rd ? ~rd_q : rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      q_q[rd_q ^ cnt_q[0]] <= c;
    end
  end

endmodule

@@ rtl/core/nra_back.sv @@
module nra_back #(
  parameter int unsigned TableDepth = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  nra_pkg::cmd_t       cmd_i,
  output logic                cmd_ready_o,
  input  logic [15:0]         prune_interval_i,
  input  logic [15:0]         advert_period_i,
  output logic                res_valid_o,
  output nra_pkg::res_t       res_o,
  input  logic                res_ready_i
);

  localparam int unsigned AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CW = $clog2(TableDepth + 1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SRCH  = 7'b0000010,
    ST_RCHK  = 7'b0000100,
    ST_PRUNE = 7'b0001000,
    ST_PCHK  = 7'b0010000,
    ST_DUMP  = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } st_e;

  // Entry memory: one write and one registered read port.
  logic [111:0] mem [TableDepth];
  logic [111:0] rdat_q;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [111:0]  wdat;

  st_e          st_q, st_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] rp_q, rp_d;
  logic [CW-1:0] wp_q, wp_d;
  logic [31:0]  now_q, now_d;
  logic [15:0]  pc_q, pc_d, ac_q, ac_d;
  logic         adv_q, adv_d;
  nra_pkg::cmd_t cur_q, cur_d;
  logic [31:0]  exp_q, exp_d;
  nra_pkg::res_t pend_q, pend_d;  // result held until the next one is known
  logic         pv_q, pv_d;
  logic         ov_q, ov_d;
  nra_pkg::res_t ob_q, ob_d;
  logic         can_out;
  logic [16:0]  pc_inc, ac_inc;
  logic [32:0]  sum;
  logic [31:0]  r_ip, r_exp;
  logic [47:0]  r_uid;

  assign r_ip  = rdat_q[111:80];
  assign r_uid = rdat_q[79:32];
  assign r_exp = rdat_q[31:0];

  assign res_valid_o = ov_q;
  assign res_o = ob_q;
  assign can_out = !ov_q || res_ready_i;
  assign cmd_ready_o = (st_q == ST_IDLE);
  assign raddr = rp_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdat;
    end
    rdat_q <= mem[raddr];
  end

  always_comb begin
    st_d = st_q; n_d = n_q; rp_d = rp_q; wp_d = wp_q; now_d = now_q;
    pc_d = pc_q; ac_d = ac_q; adv_d = adv_q; cur_d = cur_q; exp_d = exp_q;
    pend_d = pend_q; pv_d = pv_q; ov_d = ov_q; ob_d = ob_q;
    we = 1'b0; waddr = wp_q[AW-1:0]; wdat = rdat_q;
    pc_inc = {1'b0, pc_q} + 17'd1;
    ac_inc = {1'b0, ac_q} + 17'd1;
    sum = {1'b0, now_q} + {17'd0, cur_q.life};
    if (ov_q && res_ready_i) ov_d = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cur_d = cmd_i;
          rp_d = '0;
          wp_d = '0;
          case (cmd_i.cmd)
            nra_pkg::CMD_REG: st_d = ST_SRCH;
            nra_pkg::CMD_TICK: begin
              now_d = now_q + 32'd1;
              pc_d = pc_inc[15:0];
              ac_d = ac_inc[15:0];
              adv_d = 1'b0;
              if (pc_inc[15:0] >= prune_interval_i) begin
                pc_d = '0;
              end
              if (ac_inc[15:0] >= advert_period_i) begin
                ac_d = '0;
                adv_d = 1'b1;
              end
              st_d = (pc_inc[15:0] >= prune_interval_i) ? ST_PRUNE : ST_EMIT;
              if (pc_inc[15:0] < prune_interval_i) rp_d = n_q;
            end
            default: st_d = ST_DUMP;
          endcase
        end
      end
      // Issue read of entry rp; compare in ST_RCHK. At the end of the table, append the entry or report full.
      ST_SRCH: begin
        exp_d = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        if (rp_q == n_q) begin
          if (n_q < CW'(TableDepth)) begin
            we = 1'b1;
            waddr = n_q[AW-1:0];
            wdat = {cur_q.ip, cur_q.uid, exp_d};
            n_d = n_q + 1'b1;
            pend_d = '{kind: nra_pkg::KIND_JOIN, ip: cur_q.ip, uid: cur_q.uid, last: 1'b0};
          end else begin
            pend_d = '{kind: nra_pkg::KIND_FULL, ip: cur_q.ip, uid: cur_q.uid, last: 1'b0};
          end
          pv_d = 1'b1;
          st_d = ST_EMIT;
        end else begin
          st_d = ST_RCHK;
        end
      end
      ST_RCHK: begin
        if (r_ip == cur_q.ip && r_uid == cur_q.uid) begin
          we = 1'b1;
          waddr = rp_q[AW-1:0];
          wdat = {r_ip, r_uid, exp_q};
          st_d = ST_EMIT;
        end else begin
          rp_d = rp_q + 1'b1;
          st_d = ST_SRCH;
        end
      end
      // Step the scan to ST_PCHK; at its end, flush the held part, closing the item unless an advert follows.
      ST_PRUNE: begin
        if (rp_q == n_q) begin
          if (!pv_q) begin
            n_d = wp_q;
            st_d = ST_EMIT;
          end else if (can_out) begin
            ov_d = 1'b1;
            ob_d = pend_q;
            ob_d.last = !adv_q;
            pv_d = 1'b0;
            n_d = wp_q;
            st_d = ST_EMIT;
          end
        end else begin
          st_d = ST_PCHK;
        end
      end
      // Hold each expired part until the next one or the end of the scan is seen; compact live entries.
      ST_PCHK: begin
        if (r_exp < now_q) begin
          if (!pv_q || can_out) begin
            if (pv_q) begin
              ov_d = 1'b1;
              ob_d = pend_q;
            end
            pend_d = '{kind: nra_pkg::KIND_PART, ip: r_ip, uid: r_uid, last: 1'b0};
            pv_d = 1'b1;
            rp_d = rp_q + 1'b1;
            st_d = ST_PRUNE;
          end
        end else begin
          we = 1'b1;
          waddr = wp_q[AW-1:0];
          wdat = rdat_q;
          wp_d = wp_q + 1'b1;
          rp_d = rp_q + 1'b1;
          st_d = ST_PRUNE;
        end
      end
      ST_DUMP: begin
        if (rp_q == n_q) begin
          st_d = ST_IDLE;
        end else if (can_out) begin
          st_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (cur_q.cmd == nra_pkg::CMD_DUMP) begin
          if (can_out) begin
            ov_d = 1'b1;
            ob_d = '{kind: nra_pkg::KIND_ACTIVE, ip: r_ip, uid: r_uid,
                     last: (rp_q + 1'b1 == n_q)};
            rp_d = rp_q + 1'b1;
            st_d = ST_DUMP;
          end
        end else if (cur_q.cmd == nra_pkg::CMD_TICK) begin
          if (!adv_q) begin
            st_d = ST_IDLE;
          end else if (can_out) begin
            ov_d = 1'b1;
            ob_d = '{kind: nra_pkg::KIND_ADVERT, ip: '0, uid: '0, last: 1'b1};
            adv_d = 1'b0;
            st_d = ST_IDLE;
          end
        end else if (can_out) begin
          ov_d = 1'b1;
          if (pv_q) begin
            ob_d = pend_q;
            pv_d = 1'b0;
          end else begin
            ob_d = '{kind: nra_pkg::KIND_ACK, ip: cur_q.ip, uid: cur_q.uid, last: 1'b1};
            st_d = ST_IDLE;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; n_q <= '0; rp_q <= '0; wp_q <= '0; now_q <= '0;
      pc_q <= '0; ac_q <= '0; adv_q <= 1'b0; pv_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; n_q <= n_d; rp_q <= rp_d; wp_q <= wp_d; now_q <= now_d;
      pc_q <= pc_d; ac_q <= ac_d; adv_q <= adv_d; pv_q <= pv_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; exp_q <= exp_d; pend_q <= pend_d; ob_q <= ob_d;
  end

endmodule

@@ rtl/core/nra_checker.sv @@
module nra_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [2:0] kind_o,
  input logic       last_o
);

  // A waiting result holds until taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(kind_o))
    else $error("result dropped");

  // Kind codes stay in range.
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> kind_o <= nra_pkg::KIND_FULL)
    else $error("bad kind");

  // An ack always closes its item.
  a_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && kind_o == nra_pkg::KIND_ACK |-> last_o)
    else $error("ack not last");

  // Join and full never close an item.
  a_join: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (kind_o == nra_pkg::KIND_JOIN || kind_o == nra_pkg::KIND_FULL) |-> !last_o)
    else $error("join last");

endmodule

bind node_registry_with_aging nra_checker u_chk (
  .clk_i, .rst_ni, .empty, .pop, .kind_o, .last_o
);
